// ----- rtl/sma_pkg.sv -----
// Shared types, constants and codes for the stack machine execution unit.
package sma_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int WORD_BITS   = 32;
  localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
  localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);
  localparam int FIELD_BITS  = 32;
  localparam int DEPTH_BITS  = 9;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [COUNT_BITS-1:0]       count_t;
  typedef logic [ADDR_BITS-1:0]        addr_t;

  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_POP  = 3'd1,
    CMD_ADD  = 3'd2,
    CMD_SUB  = 3'd3,
    CMD_MUL  = 3'd4,
    CMD_DIV  = 3'd5,
    CMD_PEEK = 3'd6,
    CMD_HALT = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_UNDER  = 3'd1,
    ST_OVER   = 3'd2,
    ST_DIVZ   = 3'd3,
    ST_HALTED = 3'd4
  } status_t;

  typedef struct packed {
    cmd_t                         cmd;
    logic signed [FIELD_BITS-1:0] operand;
  } req_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] top_value;
    logic [DEPTH_BITS-1:0]        depth;
    status_t                      status;
    logic                         halted;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_WB
  } state_t;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_PUSH,
    UPD_POP,
    UPD_RES,
    UPD_HALT
  } upd_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load_req;
    logic    rd_en;
    logic    mul_load;
    logic    div_start;
    upd_t    upd;
    logic    emit;
    status_t status;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    cmd_t cmd;
    logic halted;
    logic empty;
    logic below_two;
    logic full;
    logic right_zero;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/stack_machine_alu.sv -----
// Top level of the stack machine execution unit.
//
//   channel   direction  handshake              payload
//   request   in         req_valid / req_ready  req (cmd, operand)
//   response  out        rsp_valid / rsp_ready  rsp (top_value, depth, status, halted)
//
// Push, pop, peek, halt, add and sub accept and read the second stack word from the
// single-port stack memory in S_IDLE, then execute and write in S_EXEC. Mul stores
// the product in S_EXEC and writes it back in S_WB; div starts the one-bit-per-cycle
// divider in S_EXEC, waits in S_DIV, then writes back in S_WB; a mul or div that
// fails its checks ends in S_EXEC. rst clears the count and the halt flag; memory
// is not cleared. A response waits in the output register while the next request is
// accepted; execution stalls only when that register is still full.
module stack_machine_alu (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  sma_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output sma_pkg::rsp_t  rsp
);
  import sma_pkg::*;

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;

  sma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  sma_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctrl      (ctrl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ----- rtl/sma_div.sv -----
// Iterative signed divider: one quotient bit per cycle, truncating toward zero.
module sma_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  sma_pkg::word_t dividend,
  input  sma_pkg::word_t divisor,
  output logic          done,
  output sma_pkg::word_t quotient
);
  import sma_pkg::*;

  localparam int CNT_BITS = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS-1:0] dvs;
  logic [CNT_BITS-1:0]  cnt;
  logic                 neg;
  logic                 run;
  logic                 fin;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS-1:0] mag_a;
  logic [WORD_BITS-1:0] mag_b;

  // Take magnitudes of the operands
  always_comb begin
    mag_a = dividend[WORD_BITS-1] ? (WORD_BITS'(0) - dividend) : dividend;
    mag_b = divisor[WORD_BITS-1] ? (WORD_BITS'(0) - divisor) : divisor;
    trial = {rem, quo[WORD_BITS-1]} - {1'b0, dvs};
  end

  // Control: run for one cycle per quotient bit, then a sign fix-up cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CNT_BITS'(1);
        if (cnt == CNT_BITS'(WORD_BITS - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  // Restoring shift-subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= mag_a;
      dvs <= mag_b;
      neg <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
    end else if (run) begin
      if (!trial[WORD_BITS]) begin
        rem <= trial[WORD_BITS-1:0];
        quo <= {quo[WORD_BITS-2:0], 1'b1};
      end else begin
        rem <= {rem[WORD_BITS-2:0], quo[WORD_BITS-1]};
        quo <= {quo[WORD_BITS-2:0], 1'b0};
      end
    end
    if (fin) begin
      quotient <= neg ? (WORD_BITS'(0) - quo) : quo;
    end
  end

endmodule

// ----- rtl/sma_datapath.sv -----
// Datapath: stack memory, top-of-stack and count registers, ALU and result register.
module sma_datapath (
  input  logic               clk,
  input  logic               rst,
  input  sma_pkg::req_t      req,
  input  sma_pkg::ctrl_cmd_t ctrl,
  output sma_pkg::dp_stat_t  stat,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output sma_pkg::rsp_t      rsp
);
  import sma_pkg::*;

  logic [WORD_BITS-1:0] mem [STACK_DEPTH];

  req_t   req_q;
  count_t count;
  count_t count_next;
  word_t  top;
  word_t  top_next;
  logic   halt_flag;
  logic   halt_next;
  word_t  rd_data;
  word_t  mul_res;
  word_t  div_q;
  logic   div_done;
  word_t  imm;
  word_t  res;
  addr_t  rd_addr;
  logic   wr_en;
  addr_t  wr_addr;
  word_t  wr_data;

  sma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (top),
    .divisor  (rd_data),
    .done     (div_done),
    .quotient (div_q)
  );

  // Decode addresses and the ALU result
  always_comb begin
    imm     = WORD_BITS'(req_q.operand);
    rd_addr = ADDR_BITS'(count - COUNT_BITS'(2));
    unique case (req_q.cmd) inside
      CMD_ADD: res = top + rd_data;
      CMD_SUB: res = top - rd_data;
      CMD_MUL: res = mul_res;
      default: res = div_q;
    endcase
    wr_en   = (ctrl.upd == UPD_PUSH) || (ctrl.upd == UPD_RES);
    wr_addr = (ctrl.upd == UPD_PUSH) ? ADDR_BITS'(count) : rd_addr;
    wr_data = (ctrl.upd == UPD_PUSH) ? imm : res;
  end

  // Next architectural state
  always_comb begin
    count_next = count;
    top_next   = top;
    halt_next  = halt_flag;
    unique case (ctrl.upd)
      UPD_PUSH: begin
        count_next = count + COUNT_BITS'(1);
        top_next   = imm;
      end
      UPD_POP: begin
        count_next = count - COUNT_BITS'(1);
        top_next   = rd_data;
      end
      UPD_RES: begin
        count_next = count - COUNT_BITS'(1);
        top_next   = res;
      end
      UPD_HALT: halt_next = 1'b1;
      default: ;
    endcase
  end

  // Report to the controller
  always_comb begin
    stat.cmd        = req_q.cmd;
    stat.halted     = halt_flag;
    stat.empty      = (count == '0);
    stat.below_two  = (count < COUNT_BITS'(2));
    stat.full       = (count >= COUNT_BITS'(STACK_DEPTH));
    stat.right_zero = (rd_data == '0);
    stat.div_done   = div_done;
    stat.out_free   = !rsp_valid || rsp_ready;
  end

  // Stack memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Hold request, product and state registers
  always_ff @(posedge clk) begin
    if (ctrl.load_req) begin
      req_q <= req;
    end
    if (ctrl.mul_load) begin
      mul_res <= top * rd_data;
    end
    top <= top_next;
    if (rst) begin
      count     <= '0;
      halt_flag <= 1'b0;
    end else begin
      count     <= count_next;
      halt_flag <= halt_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (ctrl.emit) begin
      rsp.top_value <= (count_next == '0) ? '0 : FIELD_BITS'(top_next);
      rsp.depth     <= DEPTH_BITS'(count_next);
      rsp.status    <= ctrl.status;
      rsp.halted    <= halt_next;
    end
  end

endmodule

// ----- rtl/sma_ctrl.sv -----
// Controller: sequences each request through read and execute, then divide for div and write-back for mul and div.
module sma_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  sma_pkg::dp_stat_t  stat,
  output sma_pkg::ctrl_cmd_t ctrl
);
  import sma_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
          if (!stat.halted && !stat.below_two) begin
            if (stat.cmd == CMD_MUL) begin
              state_next = S_WB;
            end else if (stat.cmd == CMD_DIV && !stat.right_zero) begin
              state_next = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req_ready      = 1'b0;
    ctrl.load_req  = 1'b0;
    ctrl.rd_en     = 1'b0;
    ctrl.mul_load  = 1'b0;
    ctrl.div_start = 1'b0;
    ctrl.upd       = UPD_NONE;
    ctrl.emit      = 1'b0;
    ctrl.status    = ST_OK;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctrl.load_req = 1'b1;
          ctrl.rd_en    = 1'b1;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          if (stat.halted) begin
            ctrl.emit   = 1'b1;
            ctrl.status = ST_HALTED;
          end else begin
            unique case (stat.cmd) inside
              CMD_PUSH: begin
                ctrl.emit = 1'b1;
                if (stat.full) begin
                  ctrl.status = ST_OVER;
                end else begin
                  ctrl.upd = UPD_PUSH;
                end
              end
              CMD_POP, CMD_PEEK: begin
                ctrl.emit = 1'b1;
                if (stat.empty) begin
                  ctrl.status = ST_UNDER;
                end else if (stat.cmd == CMD_POP) begin
                  ctrl.upd = UPD_POP;
                end
              end
              CMD_HALT: begin
                ctrl.emit = 1'b1;
                ctrl.upd  = UPD_HALT;
              end
              CMD_ADD, CMD_SUB: begin
                ctrl.emit = 1'b1;
                if (stat.below_two) begin
                  ctrl.status = ST_UNDER;
                end else begin
                  ctrl.upd = UPD_RES;
                end
              end
              CMD_MUL: begin
                if (stat.below_two) begin
                  ctrl.emit   = 1'b1;
                  ctrl.status = ST_UNDER;
                end else begin
                  ctrl.mul_load = 1'b1;
                end
              end
              default: begin
                if (stat.below_two) begin
                  ctrl.emit   = 1'b1;
                  ctrl.status = ST_UNDER;
                end else if (stat.right_zero) begin
                  ctrl.emit   = 1'b1;
                  ctrl.status = ST_DIVZ;
                end else begin
                  ctrl.div_start = 1'b1;
                end
              end
            endcase
          end
        end
      end
      S_DIV: ;
      S_WB: begin
        if (stat.out_free) begin
          ctrl.upd  = UPD_RES;
          ctrl.emit = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- tb/sv/stack_machine_alu_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the stack machine execution unit.
module stack_machine_alu_tb;
  import sma_pkg::*;

  localparam int RAND_ITEMS   = 1250;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 60;

  // Instruction mixes for the random bursts
  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_EVEN
  } mix_t;

  // One row of the directed table; has_exp marks rows whose response is typed in
  typedef struct {
    cmd_t    cmd;
    word_t   operand;
    bit      has_exp;
    word_t   top;
    int      depth;
    status_t status;
  } dir_step_t;

  localparam int DIR_ROWS = 32;
  localparam int HALT_ROW = 26;

  // Rows below HALT_ROW run right after reset, the rest close the run
  dir_step_t dir_steps [DIR_ROWS] = '{
    '{CMD_POP,  32'sd0,         1'b1, 32'sd0,         0, ST_UNDER},
    '{CMD_PEEK, 32'sd0,         1'b1, 32'sd0,         0, ST_UNDER},
    '{CMD_ADD,  32'sd0,         1'b1, 32'sd0,         0, ST_UNDER},
    '{CMD_DIV,  32'sd0,         1'b1, 32'sd0,         0, ST_UNDER},
    '{CMD_PUSH, 32'h7FFF_FFFF,  1'b1, 32'h7FFF_FFFF,  1, ST_OK},
    '{CMD_SUB,  32'sd0,         1'b1, 32'h7FFF_FFFF,  1, ST_UNDER},
    '{CMD_PUSH, 32'sd1,         1'b1, 32'sd1,         2, ST_OK},
    '{CMD_ADD,  32'sd0,         1'b1, 32'h8000_0000,  1, ST_OK},
    '{CMD_POP,  32'sd0,         1'b1, 32'sd0,         0, ST_OK},
    '{CMD_PUSH, 32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  1, ST_OK},
    '{CMD_PUSH, 32'h8000_0000,  1'b1, 32'h8000_0000,  2, ST_OK},
    '{CMD_DIV,  32'sd0,         1'b1, 32'h8000_0000,  1, ST_OK},
    '{CMD_PUSH, 32'sd0,         1'b1, 32'sd0,         2, ST_OK},
    '{CMD_PUSH, 32'sd5,         1'b1, 32'sd5,         3, ST_OK},
    '{CMD_DIV,  32'sd0,         1'b1, 32'sd5,         3, ST_DIVZ},
    '{CMD_POP,  32'sd0,         1'b0, 32'sd0,         0, ST_OK},
    '{CMD_POP,  32'sd0,         1'b0, 32'sd0,         0, ST_OK},
    '{CMD_PUSH, 32'sd2,         1'b0, 32'sd0,         0, ST_OK},
    '{CMD_PUSH, 32'hFFFF_FFF9,  1'b0, 32'sd0,         0, ST_OK},
    '{CMD_DIV,  32'sd0,         1'b0, 32'sd0,         0, ST_OK},
    '{CMD_PUSH, 32'sd3,         1'b0, 32'sd0,         0, ST_OK},
    '{CMD_MUL,  32'sd0,         1'b0, 32'sd0,         0, ST_OK},
    '{CMD_PUSH, 32'h7FFF_FFFF,  1'b0, 32'sd0,         0, ST_OK},
    '{CMD_MUL,  32'sd0,         1'b0, 32'sd0,         0, ST_OK},
    '{CMD_SUB,  32'sd0,         1'b0, 32'sd0,         0, ST_OK},
    '{CMD_PEEK, 32'sd0,         1'b0, 32'sd0,         0, ST_OK},
    '{CMD_HALT, 32'sd0,         1'b0, 32'sd0,         0, ST_OK},
    '{CMD_PUSH, 32'h5A5A_5A5A,  1'b0, 32'sd0,         0, ST_OK},
    '{CMD_POP,  32'sd0,         1'b0, 32'sd0,         0, ST_OK},
    '{CMD_DIV,  32'sd0,         1'b0, 32'sd0,         0, ST_OK},
    '{CMD_HALT, 32'sd0,         1'b0, 32'sd0,         0, ST_OK},
    '{CMD_PEEK, 32'sd0,         1'b0, 32'sd0,         0, ST_OK}
  };

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int src_idle_pct;
  int snk_stall_pct;

  // Stack machine state as the checker sees it
  word_t vm_stack [STACK_DEPTH];
  int    vm_depth  = 0;
  bit    vm_halted = 1'b0;

  rsp_t pending_rsp [$];
  rsp_t expd_rsp;
  int   mismatches = 0;
  int   rand_sent  = 0;

  stack_machine_alu DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Execute one instruction on the checker's stack and return its response
  function automatic rsp_t exec_instr(req_t r);
    word_t   lhs;
    word_t   rhs;
    word_t   res;
    status_t st;
    rsp_t    o;
    st  = ST_OK;
    res = '0;
    if (vm_halted) begin
      st = ST_HALTED;
    end else begin
      case (r.cmd)
        CMD_PUSH: begin
          if (vm_depth >= STACK_DEPTH) begin
            st = ST_OVER;
          end else begin
            vm_stack[vm_depth] = r.operand;
            vm_depth++;
          end
        end
        CMD_POP, CMD_PEEK: begin
          if (vm_depth == 0) begin
            st = ST_UNDER;
          end else if (r.cmd == CMD_POP) begin
            vm_depth--;
          end
        end
        CMD_HALT: begin
          vm_halted = 1'b1;
        end
        default: begin
          if (vm_depth < 2) begin
            st = ST_UNDER;
          end else begin
            // top word is the left operand, the one below it the right
            lhs = vm_stack[vm_depth-1];
            rhs = vm_stack[vm_depth-2];
            case (r.cmd)
              CMD_ADD: res = lhs + rhs;
              CMD_SUB: res = lhs - rhs;
              CMD_MUL: res = lhs * rhs;
              default: begin
                // widen so most-negative over minus one wraps instead of trapping
                if (rhs == 0) st = ST_DIVZ;
                else res = word_t'(longint'(lhs) / longint'(rhs));
              end
            endcase
            if (st == ST_OK) begin
              vm_stack[vm_depth-2] = res;
              vm_depth--;
            end
          end
        end
      endcase
    end
    o.top_value = (vm_depth > 0) ? vm_stack[vm_depth-1] : '0;
    o.depth     = DEPTH_BITS'(vm_depth);
    o.status    = st;
    o.halted    = vm_halted;
    return o;
  endfunction

  // Operand: full-range words in four of ten draws, else small values or the extremes
  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      4, 5, 6: return word_t'(int'($urandom_range(0, 8)) - 4);
      7:       return 32'h8000_0000;
      8:       return 32'h7FFF_FFFF;
      9:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic cmd_t pick_cmd(mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        return (roll < 60) ? CMD_PUSH : cmd_t'($urandom_range(CMD_ADD, CMD_DIV));
      end
      MIX_SHRINK: begin
        if (roll < 15) return CMD_PUSH;
        else if (roll < 45) return CMD_POP;
        else if (roll < 55) return CMD_PEEK;
        else return cmd_t'($urandom_range(CMD_ADD, CMD_DIV));
      end
      default: begin
        return cmd_t'($urandom_range(CMD_PUSH, CMD_PEEK));
      end
    endcase
  endfunction

  // Offer one request, hold it until accepted, then record its expected response
  task automatic issue(req_t r, bit has_exp, rsp_t typed_exp);
    rsp_t predicted;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    predicted = exec_instr(r);
    pending_rsp.push_back(has_exp ? typed_exp : predicted);
    @(negedge clk);
  endtask

  task automatic issue_random(cmd_t c);
    req_t r;
    r.cmd     = c;
    r.operand = rand_word();
    issue(r, 1'b0, '0);
    rand_sent++;
  endtask

  task automatic walk_rows(int lo, int hi);
    req_t r;
    rsp_t typed_exp;
    for (int i = lo; i < hi; i++) begin
      r.cmd               = dir_steps[i].cmd;
      r.operand           = dir_steps[i].operand;
      typed_exp.top_value = dir_steps[i].top;
      typed_exp.depth     = DEPTH_BITS'(dir_steps[i].depth);
      typed_exp.status    = dir_steps[i].status;
      typed_exp.halted    = 1'b0;
      issue(r, dir_steps[i].has_exp, typed_exp);
    end
  endtask

  // Push up to full depth, past it, then work at the top of the store
  task automatic fill_stack();
    while (vm_depth < STACK_DEPTH) issue_random(CMD_PUSH);
    repeat ($urandom_range(2, 4)) issue_random(CMD_PUSH);
    repeat (8) issue_random(pick_cmd(MIX_EVEN));
  endtask

  task automatic run_random(int upto);
    mix_t mix;
    while (rand_sent < upto) begin
      mix = mix_t'($urandom_range(MIX_GROW, MIX_EVEN));
      repeat ($urandom_range(8, 40)) issue_random(pick_cmd(mix));
    end
  endtask

  // Drop valid and hold off until every expected response is back
  task automatic drain_pending();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  // Randomly stall the response channel
  always @(negedge clk) begin
    rsp_ready <= !rst && ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // Compare each accepted response with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response %p", $time, rsp);
        mismatches++;
      end else begin
        expd_rsp = pending_rsp.pop_front();
        if (rsp.top_value !== expd_rsp.top_value) begin
          $display("%0t: top_value expected %0d, got %0d", $time,
                   expd_rsp.top_value, rsp.top_value);
          mismatches++;
        end
        if (rsp.depth !== expd_rsp.depth) begin
          $display("%0t: depth expected %0d, got %0d", $time, expd_rsp.depth, rsp.depth);
          mismatches++;
        end
        if (rsp.status !== expd_rsp.status) begin
          $display("%0t: status expected %0d, got %0d", $time, expd_rsp.status, rsp.status);
          mismatches++;
        end
        if (rsp.halted !== expd_rsp.halted) begin
          $display("%0t: halted expected %0d, got %0d", $time, expd_rsp.halted, rsp.halted);
          mismatches++;
        end
      end
    end
  end

  // End the run when no request or response moves for too long
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    src_idle_pct  = 16;
    snk_stall_pct = 88;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    walk_rows(0, HALT_ROW);

    // sender idles lightly, receiver stalls heavily
    fill_stack();
    run_random(RAND_ITEMS / 3);
    drain_pending();

    // sender idles heavily, receiver stalls lightly
    src_idle_pct  = 88;
    snk_stall_pct = 16;
    run_random(2 * RAND_ITEMS / 3);
    drain_pending();

    // back to back on both sides
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    fill_stack();
    run_random(RAND_ITEMS);

    // halt, then confirm later requests are answered as halted and leave the stack unchanged
    walk_rows(HALT_ROW, DIR_ROWS);
    drain_pending();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sma_pkg.sv
rtl/sma_div.sv
rtl/sma_datapath.sv
rtl/sma_ctrl.sv
rtl/stack_machine_alu.sv
tb/sv/stack_machine_alu_tb.sv
